// ===== rtl/core/mlfd_pkg.sv =====
// ----------------------------------------------------------------------------
// mlfd_pkg
// Shared types and constants for the magic/length frame deframer.
// ----------------------------------------------------------------------------
package mlfd_pkg;

  // Field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 32;
  localparam int unsigned SizeW   = 33;
  localparam int unsigned StatusW = 2;
  localparam int unsigned ShiftW  = 24;
  localparam int unsigned CountW  = 2;

  // Index of the last byte of a 4-byte word
  localparam logic [CountW-1:0] WordLastIdx = 2'd3;

  // Header word plus length word
  localparam logic [SizeW-1:0] FrameOverhead = 33'd8;

  // Reset value of the magic register
  localparam logic [WordW-1:0] MagicReset = 32'h0000_0000;

  // Frame status codes
  typedef enum logic [StatusW-1:0] {
    ST_PENDING  = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_INVALID  = 2'd2,
    ST_RETRY    = 2'd3
  } status_t;

  // Parser phase, one-hot
  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_LENGTH  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  // Input transaction
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             end_of_data;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic               payload_valid;
    logic [ByteW-1:0]   payload_byte;
    logic [StatusW-1:0] frame_status;
    logic [SizeW-1:0]   frame_bytes;
  } out_item_t;

endpackage

// ===== rtl/core/magic_length_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// magic_length_frame_deframer_unit
// Byte-stream deframer: magic header check, 32-bit length, payload pass-through.
// ----------------------------------------------------------------------------
// Takes one byte per cycle and returns one result per byte in the cycle after
// the byte is accepted. Each byte updates the parser state (phase, word
// gatherer, payload counter) with a combinational next-state computation and
// writes one result register, so a new byte can be accepted every cycle while
// the output side keeps taking results; the input stalls only when the result
// register is full and its receiver stalls. The magic word is written through
// the cfg_ port (always ready) and must only change while no frame is open.
module magic_length_frame_deframer_unit #(
  parameter logic [mlfd_pkg::WordW-1:0] MAGIC_RESET = mlfd_pkg::MagicReset
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input transactions
  input  logic                       in_valid,
  output logic                       in_stall,
  input  mlfd_pkg::in_item_t         in_data,
  // result transactions
  output logic                       out_valid,
  input  logic                       out_stall,
  output mlfd_pkg::out_item_t        out_data,
  // configuration write
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mlfd_pkg::WordW-1:0] cfg_data
);

  mlfd_pkg::phase_t                  phase_r, phase_nxt;
  logic [mlfd_pkg::CountW-1:0]       count_r, count_nxt;
  logic [mlfd_pkg::ShiftW-1:0]       shift_r, shift_nxt;
  logic [mlfd_pkg::WordW-1:0]        remain_r, remain_nxt;
  logic [mlfd_pkg::WordW-1:0]        length_r, length_nxt;
  logic [mlfd_pkg::WordW-1:0]        magic_r;
  logic                              out_valid_r;
  mlfd_pkg::out_item_t               out_data_r, result_nxt;
  logic                              in_accept;
  logic [mlfd_pkg::WordW-1:0]        word;
  logic [mlfd_pkg::WordW-1:0]        remain_dec;

  // Accept a byte when the result register is free or draining
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign word       = {shift_r, in_data.data_byte};
  assign remain_dec = remain_r - {{(mlfd_pkg::WordW-1){1'b0}}, (remain_r != '0)};

  // Next parser state and result for the byte on the input
  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    shift_nxt  = shift_r;
    remain_nxt = remain_r;
    length_nxt = length_r;
    result_nxt = '{payload_valid: 1'b0, payload_byte: '0,
                   frame_status: mlfd_pkg::ST_PENDING, frame_bytes: '0};
    unique case (phase_r)
      mlfd_pkg::PH_PAYLOAD: begin
        result_nxt.payload_valid = 1'b1;
        result_nxt.payload_byte  = in_data.data_byte;
        remain_nxt               = remain_dec;
        if (remain_dec == '0) begin
          result_nxt.frame_status = mlfd_pkg::ST_COMPLETE;
          result_nxt.frame_bytes  = {1'b0, length_r} + mlfd_pkg::FrameOverhead;
          phase_nxt  = mlfd_pkg::PH_HEADER;
          length_nxt = '0;
        end else if (in_data.end_of_data) begin
          result_nxt.frame_status = mlfd_pkg::ST_RETRY;
          phase_nxt  = mlfd_pkg::PH_HEADER;
          remain_nxt = '0;
          length_nxt = '0;
        end
      end
      default: begin
        // Header and length phases gather a big-endian word
        if (count_r != mlfd_pkg::WordLastIdx) begin
          shift_nxt = {shift_r[mlfd_pkg::ShiftW-mlfd_pkg::ByteW-1:0], in_data.data_byte};
          count_nxt = count_r + 1'b1;
          if (in_data.end_of_data) begin
            result_nxt.frame_status = mlfd_pkg::ST_RETRY;
            phase_nxt = mlfd_pkg::PH_HEADER;
            count_nxt = '0;
            shift_nxt = '0;
          end
        end else begin
          count_nxt = '0;
          shift_nxt = '0;
          if (phase_r != mlfd_pkg::PH_LENGTH) begin
            if (word != magic_r) begin
              result_nxt.frame_status = mlfd_pkg::ST_INVALID;
              phase_nxt = mlfd_pkg::PH_HEADER;
            end else if (in_data.end_of_data) begin
              result_nxt.frame_status = mlfd_pkg::ST_RETRY;
              phase_nxt = mlfd_pkg::PH_HEADER;
            end else begin
              phase_nxt = mlfd_pkg::PH_LENGTH;
            end
          end else begin
            if (word == '0) begin
              result_nxt.frame_status = mlfd_pkg::ST_COMPLETE;
              result_nxt.frame_bytes  = mlfd_pkg::FrameOverhead;
              phase_nxt = mlfd_pkg::PH_HEADER;
            end else if (in_data.end_of_data) begin
              result_nxt.frame_status = mlfd_pkg::ST_RETRY;
              phase_nxt = mlfd_pkg::PH_HEADER;
            end else begin
              phase_nxt  = mlfd_pkg::PH_PAYLOAD;
              remain_nxt = word;
              length_nxt = word;
            end
          end
        end
      end
    endcase
  end

  // Advance parser state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= mlfd_pkg::PH_HEADER;
      count_r  <= '0;
      shift_r  <= '0;
      remain_r <= '0;
      length_r <= '0;
    end else if (in_accept) begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      shift_r  <= shift_nxt;
      remain_r <= remain_nxt;
      length_r <= length_nxt;
    end
  end

  // Hold the magic word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= MAGIC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      magic_r <= cfg_data;
    end
  end

  // Result register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= result_nxt;
    end
  end

endmodule

// ===== rtl/core/mlfd_checker.sv =====
// ----------------------------------------------------------------------------
// mlfd_checker
// Port-level checks for the magic/length frame deframer.
// ----------------------------------------------------------------------------
module mlfd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input mlfd_pkg::out_item_t out_data
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Size only on a completed frame
  a_size_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.frame_status != mlfd_pkg::ST_COMPLETE)
      |-> out_data.frame_bytes == '0)
    else $error("frame size without completion");

  // Completion without a payload byte means an empty frame
  a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.frame_status == mlfd_pkg::ST_COMPLETE)
      && !out_data.payload_valid |-> out_data.frame_bytes == mlfd_pkg::FrameOverhead)
    else $error("empty frame size wrong");

  // Non-payload results carry a zero byte
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.payload_valid |-> out_data.payload_byte == '0)
    else $error("payload byte without payload");

endmodule

bind magic_length_frame_deframer_unit mlfd_checker u_mlfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
